// ===== rtl/mcvl_pkg.sv =====
// Shared types and constants for the corner-to-vertex lookup core.
// Used by mesh_corner_to_vertex_lookup_core.
// No dependencies.
package mcvl_pkg;

	localparam int MAX_RING      = 1024;
	localparam int MAX_IRREGULAR = 512;
	localparam int MAX_T0_TRIS   = 1024;
	localparam int VERTEX_BITS   = 16;

	localparam int CODE_BITS  = VERTEX_BITS + 1;
	localparam int T0_DEPTH   = 3 * MAX_T0_TRIS;
	localparam int RING_AW    = $clog2(MAX_RING);
	localparam int IRR_AW     = $clog2(MAX_IRREGULAR);
	localparam int T0_AW      = $clog2(T0_DEPTH);

	// Fixed field widths of the ports
	localparam int MODE_BITS   = 3;
	localparam int SLOT_BITS   = 12;
	localparam int WVAL_BITS   = 17;
	localparam int CORNER_BITS = 14;
	localparam int RING_BITS   = 11;
	localparam int OUT_BITS    = 16;
	localparam int OFF_BITS    = 3;
	localparam int IDX_BITS    = CORNER_BITS - OFF_BITS;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_QUERY     = 3'd0,
		MODE_LEFT_CODE = 3'd1,
		MODE_RIGHT_CODE = 3'd2,
		MODE_LEFT_IRR  = 3'd3,
		MODE_RIGHT_IRR = 3'd4,
		MODE_T0        = 3'd5
	} mode_t;

	// Corner offsets within a ring vertex
	localparam logic [OFF_BITS-1:0] OFF_SELF_A = 3'd0;
	localparam logic [OFF_BITS-1:0] OFF_LEFT   = 3'd1;
	localparam logic [OFF_BITS-1:0] OFF_NEXT_A = 3'd2;
	localparam logic [OFF_BITS-1:0] OFF_NEXT_B = 3'd4;
	localparam logic [OFF_BITS-1:0] OFF_RIGHT  = 3'd5;
	localparam logic [OFF_BITS-1:0] OFF_SELF_B = 3'd6;

	// Register index on the config port
	localparam logic REG_RING_COUNT = 1'b0;

endpackage

// ===== rtl/mcvl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for every table of the lookup core.
module mcvl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/mesh_corner_to_vertex_lookup_core.sv =====
// Laced-ring corner-to-vertex lookup core: top level, four-stage pipeline.
// Depends on mcvl_pkg and mcvl_ram.
//
// channel | handshake          | payload
// --------+--------------------+-------------------------------------------
// in      | in_valid/in_ready  | mode, table_slot, write_value, corner
// out     | out_valid/out_ready| vertex, irregular, error (queries only)
// cfg     | APB psel/penable   | paddr, pwdata, prdata; ring_count at 0x0
//
// One transaction per cycle while out is not stalled; a query result reaches out via the stage 1-4 registers.
// Stage 1 splits the corner, stage 2 reads the code tables, stage 3 reads the
// irregular lists and T0 table, stage 4 is the output register.
// Table writes land in the stage that reads that table, so order is kept.
// A stall on out freezes the whole pipeline, RAM read registers included.
// Reset clears valids and ring_count (to 1); tables are undefined until written.
module mesh_corner_to_vertex_lookup_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mcvl_pkg::APB_AW-1:0]          paddr,
	input  logic [mcvl_pkg::APB_DW-1:0]          pwdata,
	output logic [mcvl_pkg::APB_DW-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mcvl_pkg::MODE_BITS-1:0]       mode,
	input  logic [mcvl_pkg::SLOT_BITS-1:0]       table_slot,
	input  logic [mcvl_pkg::WVAL_BITS-1:0]       write_value,
	input  logic [mcvl_pkg::CORNER_BITS-1:0]     corner,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mcvl_pkg::OUT_BITS-1:0]        vertex,
	output logic                                 irregular,
	output logic                                 error
);
	import mcvl_pkg::*;

	logic                  adv;
	logic [RING_BITS-1:0]  ring_q;
	logic                  reg_sel;

	// ---------------- config port ----------------
	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_AW-1];
	assign prdata  = (reg_sel == REG_RING_COUNT) ? APB_DW'(ring_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= RING_BITS'(1);
		end else if (psel && penable && pwrite && pready && reg_sel == REG_RING_COUNT) begin
			ring_q <= pwdata[RING_BITS-1:0];
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: corner split ----------------
	logic                    t0path_in;
	logic [CORNER_BITS-1:0]  diff_in;

	assign t0path_in = corner >= {ring_q, 3'b000};
	assign diff_in   = corner - CORNER_BITS'(corner[CORNER_BITS-1:2]);

	logic                    vld_s1;
	logic [MODE_BITS-1:0]    mode_s1;
	logic [SLOT_BITS-1:0]    slot_s1;
	logic [WVAL_BITS-1:0]    wval_s1;
	logic [CORNER_BITS-1:0]  corner_s1;
	logic                    t0path_s1;
	logic [CORNER_BITS-1:0]  diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1   <= mode;
			slot_s1   <= table_slot;
			wval_s1   <= write_value;
			corner_s1 <= corner;
			t0path_s1 <= t0path_in;
			diff_s1   <= diff_in;
		end
	end

	// ---------------- stage 2: code table access ----------------
	logic [CORNER_BITS-1:0]  ring6;
	logic [CORNER_BITS-1:0]  t0idx;
	logic [IDX_BITS-1:0]     ridx;
	logic [IDX_BITS:0]       nxt_full;
	logic [RING_BITS-1:0]    nxt;
	logic                    code_slot_ok;
	logic                    we_lcode, we_rcode;
	logic [CODE_BITS-1:0]    lcode_rd, rcode_rd;

	assign ring6    = CORNER_BITS'({ring_q, 2'b00}) + CORNER_BITS'({ring_q, 1'b0});
	assign t0idx    = diff_s1 - ring6;
	assign ridx     = corner_s1[CORNER_BITS-1:OFF_BITS];
	assign nxt_full = (IDX_BITS+1)'(ridx) + (IDX_BITS+1)'(1);
	assign nxt      = (nxt_full >= (IDX_BITS+1)'(ring_q)) ? '0 : nxt_full[RING_BITS-1:0];

	assign code_slot_ok = slot_s1 < SLOT_BITS'(MAX_RING);
	assign we_lcode = adv && vld_s1 && mode_s1 == MODE_LEFT_CODE && code_slot_ok;
	assign we_rcode = adv && vld_s1 && mode_s1 == MODE_RIGHT_CODE && code_slot_ok;

	mcvl_ram #(.WIDTH(CODE_BITS), .DEPTH(MAX_RING)) u_lcode (
		.clk   (clk),
		.we    (we_lcode),
		.waddr (slot_s1[RING_AW-1:0]),
		.wdata (wval_s1[CODE_BITS-1:0]),
		.re    (adv),
		.raddr (ridx[RING_AW-1:0]),
		.rdata (lcode_rd)
	);

	mcvl_ram #(.WIDTH(CODE_BITS), .DEPTH(MAX_RING)) u_rcode (
		.clk   (clk),
		.we    (we_rcode),
		.waddr (slot_s1[RING_AW-1:0]),
		.wdata (wval_s1[CODE_BITS-1:0]),
		.re    (adv),
		.raddr (ridx[RING_AW-1:0]),
		.rdata (rcode_rd)
	);

	logic                    vld_s2;
	logic [MODE_BITS-1:0]    mode_s2;
	logic [SLOT_BITS-1:0]    slot_s2;
	logic [WVAL_BITS-1:0]    wval_s2;
	logic [OFF_BITS-1:0]     off_s2;
	logic [IDX_BITS-1:0]     ridx_s2;
	logic [RING_BITS-1:0]    nxt_s2;
	logic                    ring_ok_s2;
	logic                    t0path_s2;
	logic                    t0ok_s2;
	logic [T0_AW-1:0]        t0idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2    <= mode_s1;
			slot_s2    <= slot_s1;
			wval_s2    <= wval_s1;
			off_s2     <= corner_s1[OFF_BITS-1:0];
			ridx_s2    <= ridx;
			nxt_s2     <= nxt;
			ring_ok_s2 <= ridx < IDX_BITS'(MAX_RING);
			t0path_s2  <= t0path_s1;
			t0ok_s2    <= t0idx < CORNER_BITS'(T0_DEPTH);
			t0idx_s2   <= t0idx[T0_AW-1:0];
		end
	end

	// ---------------- stage 3: irregular list and T0 access ----------------
	logic [CODE_BITS-1:0]    code_sel;
	logic [CODE_BITS-2:0]    cidx;
	logic                    irr_slot_ok, t0_slot_ok;
	logic                    we_lirr, we_rirr, we_t0;
	logic [VERTEX_BITS-1:0]  lirr_rd, rirr_rd, t0_rd;

	assign code_sel    = (off_s2 == OFF_LEFT) ? lcode_rd : rcode_rd;
	assign cidx        = code_sel[CODE_BITS-1:1];
	assign irr_slot_ok = slot_s2 < SLOT_BITS'(MAX_IRREGULAR);
	assign t0_slot_ok  = slot_s2 < SLOT_BITS'(T0_DEPTH);
	assign we_lirr = adv && vld_s2 && mode_s2 == MODE_LEFT_IRR && irr_slot_ok;
	assign we_rirr = adv && vld_s2 && mode_s2 == MODE_RIGHT_IRR && irr_slot_ok;
	assign we_t0   = adv && vld_s2 && mode_s2 == MODE_T0 && t0_slot_ok;

	mcvl_ram #(.WIDTH(VERTEX_BITS), .DEPTH(MAX_IRREGULAR)) u_lirr (
		.clk   (clk),
		.we    (we_lirr),
		.waddr (slot_s2[IRR_AW-1:0]),
		.wdata (wval_s2[VERTEX_BITS-1:0]),
		.re    (adv),
		.raddr (lcode_rd[IRR_AW:1]),
		.rdata (lirr_rd)
	);

	mcvl_ram #(.WIDTH(VERTEX_BITS), .DEPTH(MAX_IRREGULAR)) u_rirr (
		.clk   (clk),
		.we    (we_rirr),
		.waddr (slot_s2[IRR_AW-1:0]),
		.wdata (wval_s2[VERTEX_BITS-1:0]),
		.re    (adv),
		.raddr (rcode_rd[IRR_AW:1]),
		.rdata (rirr_rd)
	);

	mcvl_ram #(.WIDTH(VERTEX_BITS), .DEPTH(T0_DEPTH)) u_t0 (
		.clk   (clk),
		.we    (we_t0),
		.waddr (slot_s2[T0_AW-1:0]),
		.wdata (wval_s2[VERTEX_BITS-1:0]),
		.re    (adv),
		.raddr (t0idx_s2),
		.rdata (t0_rd)
	);

	logic                    vld_s3;
	logic                    query_s3;
	logic [OFF_BITS-1:0]     off_s3;
	logic [IDX_BITS-1:0]     ridx_s3;
	logic [RING_BITS-1:0]    nxt_s3;
	logic                    ring_ok_s3;
	logic                    t0path_s3;
	logic                    t0ok_s3;
	logic                    code_irr_s3;
	logic [CODE_BITS-2:0]    cidx_s3;
	logic                    irr_ok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			query_s3    <= mode_s2 == MODE_QUERY;
			off_s3      <= off_s2;
			ridx_s3     <= ridx_s2;
			nxt_s3      <= nxt_s2;
			ring_ok_s3  <= ring_ok_s2;
			t0path_s3   <= t0path_s2;
			t0ok_s3     <= t0ok_s2;
			code_irr_s3 <= code_sel[0];
			cidx_s3     <= cidx;
			irr_ok_s3   <= cidx < (CODE_BITS-1)'(MAX_IRREGULAR);
		end
	end

	// ---------------- stage 4: result select and output register ----------------
	logic                    res_ok;
	logic                    res_irr;
	logic [VERTEX_BITS-1:0]  res_vert;
	logic [VERTEX_BITS-1:0]  irr_rd;

	assign irr_rd = (off_s3 == OFF_LEFT) ? lirr_rd : rirr_rd;

	always_comb begin
		res_ok   = 1'b1;
		res_irr  = 1'b0;
		res_vert = '0;
		if (t0path_s3) begin
			res_ok   = t0ok_s3;
			res_vert = t0_rd;
		end else begin
			case (off_s3) inside
				OFF_SELF_A, OFF_SELF_B: begin
					res_vert = VERTEX_BITS'(ridx_s3);
				end
				OFF_NEXT_A, OFF_NEXT_B: begin
					res_vert = VERTEX_BITS'(nxt_s3);
				end
				OFF_LEFT, OFF_RIGHT: begin
					res_ok   = ring_ok_s3 && (!code_irr_s3 || irr_ok_s3);
					res_irr  = code_irr_s3;
					res_vert = code_irr_s3 ? irr_rd : VERTEX_BITS'(cidx_s3);
				end
				default: begin
					res_ok = 1'b0;
				end
			endcase
		end
		if (!res_ok) begin
			res_vert = '0;
			res_irr  = 1'b0;
		end
	end

	logic                    out_valid_q;
	logic [OUT_BITS-1:0]     vertex_q;
	logic                    irregular_q;
	logic                    error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s3 && query_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vertex_q    <= OUT_BITS'(res_vert);
			irregular_q <= res_irr;
			error_q     <= !res_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex    = vertex_q;
	assign irregular = irregular_q;
	assign error     = error_q;

`ifndef SYNTHESIS
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> vertex == '0 && !irregular)
		else $error("error result carries a vertex or irregular flag");

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s3 && query_s3 |=> out_valid)
		else $error("query in last stage did not reach the output");

	a_no_write_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> !(we_lcode || we_rcode || we_lirr || we_rirr || we_t0))
		else $error("table written while pipeline stalled");
`endif

endmodule
